FILE: rtl/lbpm_pkg.sv
// lbpm_pkg: shared types, widths, constants and bit-level helpers for the
// busy percentage monitor. Used by every module in rtl/.
// No dependencies.
`default_nettype none

package lbpm_pkg;

  // field widths
  localparam int IDX_W   = 6;
  localparam int CTR_W   = 64;
  localparam int PCT_W   = 15;
  localparam int SUM_W   = 21;
  localparam int CFG_W   = 7;
  localparam int QUOT_W  = 21;

  // scaled product n*25 (the remaining 2^10 of 25600 is a shift)
  localparam int MUL_W      = CTR_W + 5;
  localparam int SER_CYCLES = MUL_W;
  localparam int SER_CNT_W  = 7;
  localparam int DIV_CNT_W  = 5;
  localparam int LOW_W      = QUOT_W;

  // divider step counts
  localparam logic [DIV_CNT_W-1:0] STEPS_BUSY = DIV_CNT_W'(PCT_W);
  localparam logic [DIV_CNT_W-1:0] STEPS_MEAN = DIV_CNT_W'(SUM_W);

  // stream widths
  localparam int IN_TDATA_W  = 200;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;

  // 100 percent in Q7.8 and sum saturation
  localparam logic [PCT_W-1:0] FULL_Q  = PCT_W'(25600);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam int MAX_LP_DEF = 64;

  // one processor's counter set, as stored in the history memory
  typedef struct packed {
    logic [CTR_W-1:0] user;
    logic [CTR_W-1:0] kernel;
    logic [CTR_W-1:0] idle;
  } ctr_set_t;

  // serial datapath status
  typedef struct packed {
    logic done;
    logic skip;
  } ser_stat_t;

  // divider control
  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SER,
    ST_DIVB,
    ST_AGG,
    ST_DIVM,
    ST_OUT
  } lbpm_state_t;

  // full adder, returns {carry, sum}
  function automatic logic [1:0] add_bit(input logic a, input logic b, input logic c);
    add_bit = {(a & b) | (a & c) | (b & c), a ^ b ^ c};
  endfunction

  // full subtractor a - b - bin, returns {borrow, diff}
  function automatic logic [1:0] sub_bit(input logic a, input logic b, input logic bin);
    sub_bit = {(~a & (b | bin)) | (b & bin), a ^ b ^ bin};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lbpm_hist.sv
// lbpm_hist: history memory holding the previous counter set per processor.
// Depends on lbpm_pkg (ctr_set_t).
`default_nettype none

module lbpm_hist #(
  parameter  int MAX_LP = lbpm_pkg::MAX_LP_DEF,
  localparam int AW     = (MAX_LP > 1) ? $clog2(MAX_LP) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output      lbpm_pkg::ctr_set_t    rd_data,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire lbpm_pkg::ctr_set_t    wr_data
);

  lbpm_pkg::ctr_set_t mem [MAX_LP];
  lbpm_pkg::ctr_set_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/lbpm_serial.sv
// lbpm_serial: bit-serial datapath, lsb first. Forms the wrapped deltas,
// den = dk + du, num = den - di and num*25 one bit per cycle.
// Depends on lbpm_pkg (ctr_set_t, ser_stat_t, add_bit, sub_bit).
`default_nettype none

module lbpm_serial (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire lbpm_pkg::ctr_set_t                cur,
  input  wire lbpm_pkg::ctr_set_t                prev,
  output      lbpm_pkg::ser_stat_t               stat,
  output      logic [lbpm_pkg::CTR_W-1:0]        den,
  output      logic [lbpm_pkg::MUL_W-1:0]        num25
);

  localparam int CW = lbpm_pkg::CTR_W;
  localparam int MW = lbpm_pkg::MUL_W;
  localparam int NW = lbpm_pkg::SER_CNT_W;

  logic          run_r;
  logic          done_r;
  logic [NW-1:0] cnt_r;

  // operand shift registers
  logic [CW-1:0] ci_r, ck_r, cu_r, pi_r, pk_r, pu_r;
  logic [CW-1:0] d_r;
  logic [MW-1:0] m_r;
  logic          bi_r, bk_r, bu_r, cd_r, bn_r, dz_r;
  logic [3:0]    nh_r;
  logic [1:0]    mc_r;

  logic          active;
  logic [1:0]    r_i, r_k, r_u, r_d, r_n;
  logic          n_t;
  logic [2:0]    msum;

  // bit-level arithmetic of this cycle
  always_comb begin
    active = (cnt_r < NW'(CW));
    r_i    = lbpm_pkg::sub_bit(ci_r[0], pi_r[0], bi_r);
    r_k    = lbpm_pkg::sub_bit(ck_r[0], pk_r[0], bk_r);
    r_u    = lbpm_pkg::sub_bit(cu_r[0], pu_r[0], bu_r);
    r_d    = lbpm_pkg::add_bit(r_k[0], r_u[0], cd_r);
    r_n    = lbpm_pkg::sub_bit(r_d[0], r_i[0], bn_r);
    n_t    = active & r_n[0];
    // num*25 = num + num*8 + num*16
    msum   = 3'(n_t) + 3'(nh_r[2]) + 3'(nh_r[3]) + 3'(mc_r);
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + NW'(1);
        if (cnt_r == NW'(lbpm_pkg::SER_CYCLES - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift registers and carries
  always_ff @(posedge clk) begin
    if (start) begin
      ci_r <= cur.idle;
      ck_r <= cur.kernel;
      cu_r <= cur.user;
      pi_r <= prev.idle;
      pk_r <= prev.kernel;
      pu_r <= prev.user;
      bi_r <= 1'b0;
      bk_r <= 1'b0;
      bu_r <= 1'b0;
      cd_r <= 1'b0;
      bn_r <= 1'b0;
      dz_r <= 1'b1;
      nh_r <= '0;
      mc_r <= '0;
    end else if (run_r) begin
      if (active) begin
        ci_r <= ci_r >> 1;
        ck_r <= ck_r >> 1;
        cu_r <= cu_r >> 1;
        pi_r <= pi_r >> 1;
        pk_r <= pk_r >> 1;
        pu_r <= pu_r >> 1;
        bi_r <= r_i[1];
        bk_r <= r_k[1];
        bu_r <= r_u[1];
        cd_r <= r_d[1];
        bn_r <= r_n[1];
        dz_r <= dz_r & ~r_d[0];
        d_r  <= {r_d[0], d_r[CW-1:1]};
      end
      nh_r <= {nh_r[2:0], n_t};
      mc_r <= msum[2:1];
      m_r  <= {msum[0], m_r[MW-1:1]};
    end
  end

  // idle above total or zero total gives zero busy
  assign stat.done = done_r;
  assign stat.skip = bn_r | dz_r;
  assign den       = d_r;
  assign num25     = m_r;

endmodule

`default_nettype wire

FILE: rtl/lbpm_div.sv
// lbpm_div: shared restoring divider, one quotient bit per cycle.
// Used for the per-processor busy ratio and the frame mean.
// Depends on lbpm_pkg (div_ctl_t, widths).
`default_nettype none

module lbpm_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire lbpm_pkg::div_ctl_t                 ctl,
  input  wire logic [lbpm_pkg::CTR_W-1:0]         rem_init,
  input  wire logic [lbpm_pkg::LOW_W-1:0]         low_init,
  input  wire logic [lbpm_pkg::CTR_W-1:0]         divisor,
  output      logic                               done,
  output      logic [lbpm_pkg::QUOT_W-1:0]        quot
);

  localparam int CW = lbpm_pkg::CTR_W;
  localparam int LW = lbpm_pkg::LOW_W;
  localparam int QW = lbpm_pkg::QUOT_W;
  localparam int KW = lbpm_pkg::DIV_CNT_W;

  logic          run_r;
  logic          done_r;
  logic [KW-1:0] cnt_r;
  logic [CW-1:0] rem_r;
  logic [CW-1:0] div_r;
  logic [LW-1:0] low_r;
  logic [QW-1:0] q_r;

  logic [CW:0]   r2;
  logic [CW:0]   diff;
  logic          ge;

  // one trial subtraction
  always_comb begin
    r2   = {rem_r, low_r[LW-1]};
    diff = r2 - {1'b0, div_r};
    ge   = (r2 >= {1'b0, div_r});
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        run_r <= 1'b1;
        cnt_r <= ctl.steps;
      end else if (run_r) begin
        cnt_r <= cnt_r - KW'(1);
        if (cnt_r == KW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder, dividend bits and quotient
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= rem_init;
      low_r <= low_init;
      div_r <= divisor;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= ge ? diff[CW-1:0] : r2[CW-1:0];
      low_r <= low_r << 1;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

FILE: rtl/lp_busy_percent_monitor.sv
// Busy percentage monitor: one item at a time. A computed item goes through
// a memory read, the bit-serial pass over the 69-bit scaled numerator, the
// busy divider, aggregate and output; a zero or exceeded total skips the
// divider; a frame end with a reported mean adds a divider pass for the mean;
// baseline items skip the serial pass and the divider, and out-of-range items
// go from the read to output. A new item is taken once the result is loaded.
// Synchronous active-low reset clears control, lp_count to 1; history is not cleared.
`default_nettype none

module lp_busy_percent_monitor #(
  parameter int MAX_LP = lbpm_pkg::MAX_LP_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // lp_index, idle_time, kernel_time, user_time (lsb up), zero padded
  input  wire logic [lbpm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  // out_lp_index, busy_pct, total_pct, max_pct (lsb up), zero padded
  output      logic [lbpm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // busy_valid, frame_ok (lsb up)
  output      logic [lbpm_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output      logic                                out_tlast,
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_we,
  input  wire logic [lbpm_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int AW = (MAX_LP > 1) ? $clog2(MAX_LP) : 1;
  localparam int IW = lbpm_pkg::IDX_W;
  localparam int CW = lbpm_pkg::CTR_W;
  localparam int PW = lbpm_pkg::PCT_W;
  localparam int SW = lbpm_pkg::SUM_W;
  localparam int FW = lbpm_pkg::CFG_W;
  localparam int QW = lbpm_pkg::QUOT_W;
  localparam int MW = lbpm_pkg::MUL_W;
  localparam int LW = lbpm_pkg::LOW_W;

  lbpm_pkg::lbpm_state_t state_r, state_nxt;

  logic [FW-1:0]      cfg_r;
  logic [IW-1:0]      idx_r;
  lbpm_pkg::ctr_set_t cur_r;
  logic               last_r, last_nxt;
  logic               base_r, base_nxt;
  logic               skip1_r, skip1_nxt;
  logic [SW-1:0]      sum_r, sum_nxt;
  logic [PW-1:0]      max_r, max_nxt;
  logic [PW-1:0]      busy_r, busy_nxt;
  logic               bvalid_r, bvalid_nxt;
  logic [PW-1:0]      total_r, total_nxt;
  logic [PW-1:0]      mx_r, mx_nxt;
  logic               ok_r, ok_nxt;

  logic [lbpm_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [lbpm_pkg::OUT_TUSER_W-1:0] out_tuser_r;
  logic                             out_tlast_r;
  logic                             out_tvalid_r;
  logic                             out_load;

  logic [FW-1:0]      n_eff;
  logic               in_range;
  logic               is_last;
  logic               accept;

  lbpm_pkg::ctr_set_t  prev_data;
  lbpm_pkg::ctr_set_t  in_set;
  logic                wr_en;
  logic                ser_start;
  lbpm_pkg::ser_stat_t ser_stat;
  logic [CW-1:0]       den;
  logic [MW-1:0]       num25;

  lbpm_pkg::div_ctl_t  div_ctl;
  logic [CW-1:0]       div_rem;
  logic [LW-1:0]       div_low;
  logic [CW-1:0]       div_dvs;
  logic                div_done;
  logic [QW-1:0]       quot;

  logic [SW:0]         sum_add;
  logic [SW-1:0]       sum_v;
  logic [PW-1:0]       max_v;

  // input request fields
  assign in_set.idle   = in_tdata[IW+CW-1:IW];
  assign in_set.kernel = in_tdata[IW+2*CW-1:IW+CW];
  assign in_set.user   = in_tdata[IW+3*CW-1:IW+2*CW];

  assign in_tready = (state_r == lbpm_pkg::ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  // effective processor count and frame position
  always_comb begin
    if (cfg_r == '0) begin
      n_eff = FW'(1);
    end else if (32'(cfg_r) > 32'(MAX_LP)) begin
      n_eff = FW'(MAX_LP);
    end else begin
      n_eff = cfg_r;
    end
    in_range = ({1'b0, idx_r} < n_eff);
    is_last  = ({1'b0, idx_r} == (n_eff - FW'(1)));
  end

  // saturating frame sum and running maximum
  always_comb begin
    sum_add = {1'b0, sum_r} + (SW + 1)'(busy_r);
    sum_v   = sum_add[SW] ? lbpm_pkg::SUM_MAX : sum_add[SW-1:0];
    max_v   = (busy_r > max_r) ? busy_r : max_r;
  end

  // history memory
  lbpm_hist #(.MAX_LP(MAX_LP)) u_hist (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (AW'(in_tdata[IW-1:0])),
    .rd_data (prev_data),
    .wr_en   (wr_en),
    .wr_addr (AW'(idx_r)),
    .wr_data (cur_r)
  );

  // serial delta and scaling datapath
  lbpm_serial u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ser_start),
    .cur   (cur_r),
    .prev  (prev_data),
    .stat  (ser_stat),
    .den   (den),
    .num25 (num25)
  );

  // shared divider
  lbpm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .rem_init (div_rem),
    .low_init (div_low),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (quot)
  );

  // sequencer: next state and datapath controls
  always_comb begin
    state_nxt  = state_r;
    last_nxt   = last_r;
    base_nxt   = base_r;
    skip1_nxt  = skip1_r;
    sum_nxt    = sum_r;
    max_nxt    = max_r;
    busy_nxt   = busy_r;
    bvalid_nxt = bvalid_r;
    total_nxt  = total_r;
    mx_nxt     = mx_r;
    ok_nxt     = ok_r;
    wr_en      = 1'b0;
    ser_start  = 1'b0;
    out_load   = 1'b0;
    div_ctl    = '{start: 1'b0, steps: lbpm_pkg::STEPS_MEAN};
    div_rem    = '0;
    div_low    = sum_v;
    div_dvs    = CW'(n_eff);

    unique case (state_r)
      lbpm_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = lbpm_pkg::ST_READ;
        end
      end

      lbpm_pkg::ST_READ: begin
        busy_nxt   = '0;
        total_nxt  = '0;
        mx_nxt     = '0;
        ok_nxt     = 1'b0;
        bvalid_nxt = base_r & in_range;
        last_nxt   = in_range & is_last;
        if (!in_range) begin
          state_nxt = lbpm_pkg::ST_OUT;
        end else begin
          wr_en = 1'b1;
          if (base_r) begin
            ser_start = 1'b1;
            state_nxt = lbpm_pkg::ST_SER;
          end else begin
            state_nxt = lbpm_pkg::ST_AGG;
          end
        end
      end

      lbpm_pkg::ST_SER: begin
        if (ser_stat.done) begin
          if (ser_stat.skip) begin
            state_nxt = lbpm_pkg::ST_AGG;
          end else begin
            // quotient of (num*25 << 10) / den, top 64 bits already below den
            div_ctl   = '{start: 1'b1, steps: lbpm_pkg::STEPS_BUSY};
            div_rem   = num25[MW-1:5];
            div_low   = {num25[4:0], (LW - 5)'(0)};
            div_dvs   = den;
            state_nxt = lbpm_pkg::ST_DIVB;
          end
        end
      end

      lbpm_pkg::ST_DIVB: begin
        if (div_done) begin
          busy_nxt  = (quot > QW'(lbpm_pkg::FULL_Q)) ? lbpm_pkg::FULL_Q : quot[PW-1:0];
          state_nxt = lbpm_pkg::ST_AGG;
        end
      end

      lbpm_pkg::ST_AGG: begin
        if (base_r) begin
          sum_nxt = sum_v;
          max_nxt = max_v;
        end
        state_nxt = lbpm_pkg::ST_OUT;
        if (last_r) begin
          sum_nxt = '0;
          max_nxt = '0;
          if (!base_r) begin
            base_nxt = 1'b1;
          end else if (!skip1_r) begin
            skip1_nxt = 1'b1;
          end else begin
            // frame mean over the effective count
            ok_nxt    = 1'b1;
            mx_nxt    = max_v;
            div_ctl   = '{start: 1'b1, steps: lbpm_pkg::STEPS_MEAN};
            state_nxt = lbpm_pkg::ST_DIVM;
          end
        end
      end

      lbpm_pkg::ST_DIVM: begin
        if (div_done) begin
          total_nxt = (quot > QW'(lbpm_pkg::FULL_Q)) ? lbpm_pkg::FULL_Q : quot[PW-1:0];
          state_nxt = lbpm_pkg::ST_OUT;
        end
      end

      lbpm_pkg::ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = lbpm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lbpm_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lbpm_pkg::ST_IDLE;
      cfg_r        <= FW'(1);
      base_r       <= 1'b0;
      skip1_r      <= 1'b0;
      sum_r        <= '0;
      max_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      skip1_r <= skip1_nxt;
      sum_r   <= sum_nxt;
      max_r   <= max_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // item payload and result staging
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= in_tdata[IW-1:0];
      cur_r <= in_set;
    end
    last_r   <= last_nxt;
    busy_r   <= busy_nxt;
    bvalid_r <= bvalid_nxt;
    total_r  <= total_nxt;
    mx_r     <= mx_nxt;
    ok_r     <= ok_nxt;
    if (out_load) begin
      out_tdata_r <= {(lbpm_pkg::OUT_TDATA_W - IW - 3 * PW)'(0), mx_r, total_r, busy_r, idx_r};
      out_tuser_r <= {ok_r, bvalid_r};
      out_tlast_r <= last_r;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign out_tvalid = out_tvalid_r;

`ifndef ASSERT_OFF
  a_ok_only_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tlast)
    else $error("frame_ok set on a result that does not end a frame");

  a_busy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[IW+PW-1:IW] <= lbpm_pkg::FULL_Q))
    else $error("busy_pct above 100 percent");

  a_no_busy_without_baseline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[IW+PW-1:IW] == '0))
    else $error("busy_pct nonzero without a baseline");

  a_no_aggregate_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1]) |-> (out_tdata[IW+3*PW-1:IW+PW] == '0))
    else $error("aggregate fields nonzero while frame_ok is low");

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while one is in flight");
`endif

endmodule

`default_nettype wire

FILE: test/testbench.sv
// testbench for lp_busy_percent_monitor: drives per-processor counter requests
// and checks every result against a scoreboard that predicts busy percent.
// Depends on rtl/lbpm_pkg.sv and rtl/lp_busy_percent_monitor.sv.
`timescale 1ns / 100ps

module testbench;

  // widths and constants taken from the shared package
  localparam int IDX_W       = lbpm_pkg::IDX_W;
  localparam int CTR_W       = lbpm_pkg::CTR_W;
  localparam int PCT_W       = lbpm_pkg::PCT_W;
  localparam int SUM_W       = lbpm_pkg::SUM_W;
  localparam int CFG_W       = lbpm_pkg::CFG_W;
  localparam int IN_TDATA_W  = lbpm_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = lbpm_pkg::OUT_TDATA_W;
  localparam int OUT_TUSER_W = lbpm_pkg::OUT_TUSER_W;
  localparam int MAX_LP_DEF  = lbpm_pkg::MAX_LP_DEF;
  localparam logic [PCT_W-1:0] FULL_Q  = lbpm_pkg::FULL_Q;
  localparam logic [SUM_W-1:0] SUM_MAX = lbpm_pkg::SUM_MAX;

  localparam int N_ITEMS = 1450;

  // one expected result, fields as the block reports them
  typedef struct packed {
    logic [IDX_W-1:0] lp;
    logic [PCT_W-1:0] busy;
    logic             busy_valid;
    logic             frame_end;
    logic [PCT_W-1:0] total;
    logic [PCT_W-1:0] peak;
    logic             frame_ok;
  } util_result_t;

  // shapes of counter deltas for generated requests
  typedef enum int {
    CM_TYPICAL,
    CM_ZERO_DEN,
    CM_IDLE_OVER,
    CM_FULL_BUSY,
    CM_BIG,
    CM_WIDE
  } ctr_mode_t;

  // busy percent predictor and store of pending results
  class util_scoreboard;
    logic [CFG_W-1:0] lp_count;
    logic [CTR_W-1:0] last_idle   [MAX_LP_DEF];
    logic [CTR_W-1:0] last_kernel [MAX_LP_DEF];
    logic [CTR_W-1:0] last_user   [MAX_LP_DEF];
    bit               baseline_seen;
    bit               first_skipped;
    logic [SUM_W-1:0] busy_sum;
    logic [PCT_W-1:0] busy_peak;
    util_result_t     pending_results[$];
    int unsigned      mismatches;

    function new();
      lp_count      = 1;
      baseline_seen = 0;
      first_skipped = 0;
      busy_sum      = '0;
      busy_peak     = '0;
      mismatches    = 0;
      for (int j = 0; j < MAX_LP_DEF; j++) begin
        last_idle[j]   = '0;
        last_kernel[j] = '0;
        last_user[j]   = '0;
      end
    endfunction

    function int unsigned active_count();
      if (lp_count == 0) return 1;
      if (lp_count > MAX_LP_DEF) return MAX_LP_DEF;
      return lp_count;
    endfunction

    // floor(25600 * (1 - di/d)) with d = dk + du, exact over 128 bits
    function logic [PCT_W-1:0] busy_q78(input logic [CTR_W-1:0] di, input logic [CTR_W-1:0] dk,
                                        input logic [CTR_W-1:0] du);
      logic [CTR_W-1:0] den;
      logic [127:0]     prod;
      logic [127:0]     quo;
      den = dk + du;
      if (den == 0 || di >= den) return '0;
      prod = {64'd0, den - di} * 128'd25600;
      quo  = prod / {64'd0, den};
      if (quo > 128'd25600) quo = 128'd25600;
      return quo[PCT_W-1:0];
    endfunction

    // accepted request: update history and aggregate, queue the result
    function void note_request(input logic [IDX_W-1:0] idx, input logic [CTR_W-1:0] idle_v,
                               input logic [CTR_W-1:0] kern_v, input logic [CTR_W-1:0] user_v);
      util_result_t     r;
      int unsigned      n;
      logic [SUM_W:0]   wide_sum;
      logic [SUM_W-1:0] mean;
      r    = '0;
      r.lp = idx;
      n    = active_count();
      if (idx >= n) begin
        pending_results.push_back(r);
        return;
      end
      r.frame_end = (idx == n - 1);
      if (baseline_seen) begin
        r.busy = busy_q78(idle_v - last_idle[idx], kern_v - last_kernel[idx],
                          user_v - last_user[idx]);
        r.busy_valid = 1'b1;
        wide_sum = {1'b0, busy_sum} + (SUM_W+1)'(r.busy);
        busy_sum = (wide_sum > {1'b0, SUM_MAX}) ? SUM_MAX : wide_sum[SUM_W-1:0];
        if (r.busy > busy_peak) busy_peak = r.busy;
      end
      last_idle[idx]   = idle_v;
      last_kernel[idx] = kern_v;
      last_user[idx]   = user_v;
      if (r.frame_end) begin
        if (!baseline_seen) begin
          baseline_seen = 1;
        end else if (!first_skipped) begin
          first_skipped = 1;
        end else begin
          r.frame_ok = 1'b1;
          mean       = busy_sum / SUM_W'(n);
          r.total    = (mean > SUM_W'(FULL_Q)) ? FULL_Q : mean[PCT_W-1:0];
          r.peak     = busy_peak;
        end
        busy_sum  = '0;
        busy_peak = '0;
      end
      pending_results.push_back(r);
    endfunction

    task report_mismatch(input string what, input longint unsigned expv,
                         input longint unsigned gotv);
      $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, expv, gotv);
      mismatches++;
    endtask

    // accepted result: compare with the oldest pending one
    task check_result(input logic [OUT_TDATA_W-1:0] tdata, input logic [OUT_TUSER_W-1:0] tuser,
                      input logic tlast);
      util_result_t e;
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending, lp", 0, tdata[5:0]);
        return;
      end
      e = pending_results.pop_front();
      if (tdata[5:0] !== e.lp)        report_mismatch("out_lp_index", e.lp, tdata[5:0]);
      if (tdata[20:6] !== e.busy)     report_mismatch("busy_pct", e.busy, tdata[20:6]);
      if (tdata[35:21] !== e.total)   report_mismatch("total_pct", e.total, tdata[35:21]);
      if (tdata[50:36] !== e.peak)    report_mismatch("max_pct", e.peak, tdata[50:36]);
      if (tuser[0] !== e.busy_valid)  report_mismatch("busy_valid", e.busy_valid, tuser[0]);
      if (tuser[1] !== e.frame_ok)    report_mismatch("frame_ok", e.frame_ok, tuser[1]);
      if (tlast !== e.frame_end)      report_mismatch("frame_end", e.frame_end, tlast);
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_we;
  logic [CFG_W-1:0]       cfg_wdata;

  util_scoreboard sb;
  bit             calm;
  int unsigned    counted_items;
  int unsigned    sat_bursts;

  lp_busy_percent_monitor #(
    .MAX_LP(MAX_LP_DEF)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, none during calm phases
  initial begin
    int r;
    int len;
    out_tready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (calm || r < 60) begin
        len = $urandom_range(1, 30);
        @(negedge clk);
        out_tready <= 1'b1;
      end else if (r < 92) begin
        len = $urandom_range(1, 3);
        @(negedge clk);
        out_tready <= 1'b0;
      end else begin
        len = $urandom_range(20, 100);
        @(negedge clk);
        out_tready <= 1'b0;
      end
      repeat (len - 1) @(negedge clk);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  function automatic logic [CTR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic ctr_mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CM_TYPICAL;
    if (r < 78) return CM_ZERO_DEN;
    if (r < 85) return CM_IDLE_OVER;
    if (r < 92) return CM_FULL_BUSY;
    if (r < 96) return CM_BIG;
    return CM_WIDE;
  endfunction

  // one request on the input side, held until accepted
  task send_raw(input logic [IDX_W-1:0] idx, input logic [CTR_W-1:0] idle_v,
                input logic [CTR_W-1:0] kern_v, input logic [CTR_W-1:0] user_v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tdata  <= IN_TDATA_W'({user_v, kern_v, idle_v, idx});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (idx < sb.active_count()) counted_items++;
    sb.note_request(idx, idle_v, kern_v, user_v);
  endtask

  // counters built from the last stored ones plus a delta of the given shape, fully random for CM_WIDE
  task send_mode(input logic [IDX_W-1:0] idx, input ctr_mode_t mode);
    logic [CTR_W-1:0] di;
    logic [CTR_W-1:0] dk;
    logic [CTR_W-1:0] du;
    case (mode)
      CM_TYPICAL: begin
        dk = $urandom_range(0, 1 << 30);
        du = $urandom_range(0, 1 << 30);
        di = $urandom_range(0, 32'(dk + du));
      end
      CM_ZERO_DEN: begin
        dk = '0;
        du = '0;
        di = rand64();
      end
      CM_IDLE_OVER: begin
        dk = $urandom_range(0, 1 << 20);
        du = $urandom_range(0, 1 << 20);
        di = dk + du + $urandom_range(0, 1000);
      end
      CM_FULL_BUSY: begin
        dk = $urandom_range(1, 1 << 30);
        du = $urandom_range(0, 1 << 30);
        di = '0;
      end
      default: begin
        dk = rand64();
        du = rand64();
        di = rand64();
      end
    endcase
    if (mode == CM_WIDE)
      send_raw(idx, rand64(), rand64(), rand64());
    else
      send_raw(idx, sb.last_idle[idx] + di, sb.last_kernel[idx] + dk, sb.last_user[idx] + du);
  endtask

  // drop valid and let every pending result drain
  task wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task write_count(input logic [CFG_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.lp_count = value;
  endtask

  // one frame: mostly ascending and complete, sometimes scrambled or a sum overflow
  task run_frame();
    int unsigned n;
    int          s;
    int          len;
    n = sb.active_count();
    s = $urandom_range(0, 99);
    if (s < 80) begin
      for (int j = 0; j < n; j++) send_mode(IDX_W'(j), pick_mode());
    end else if (s < 99 || n < 2 || sat_bursts >= 3) begin
      len = $urandom_range(1, 2 * n);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 99) < 85)
          send_mode(IDX_W'($urandom_range(0, n - 1)), pick_mode());
        else
          send_mode(IDX_W'($urandom_range(0, MAX_LP_DEF - 1)), pick_mode());
      end
    end else begin
      // repeated fully busy processor drives the sum into saturation
      sat_bursts++;
      for (int j = 0; j < 90; j++) send_mode('0, CM_FULL_BUSY);
      send_mode(IDX_W'(n - 1), CM_FULL_BUSY);
    end
  endtask

  initial begin
    int r;
    int frames;
    sb            = new();
    calm          = 0;
    counted_items = 0;
    sat_bursts    = 0;
    rst_n         = 1'b0;
    in_tdata      = '0;
    in_tvalid     = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset count is one, so this index is ignored
    send_raw(6'd5, rand64(), rand64(), rand64());

    // baseline over all processors, extreme counters on the first two
    write_count(7'd64);
    send_raw(6'd0, '0, '0, '0);
    send_raw(6'd1, '1, '1, '1);
    for (int j = 2; j < MAX_LP_DEF; j++) send_raw(IDX_W'(j), rand64(), rand64(), rand64());

    // count zero acts as one: second frame, then first reported frame
    write_count(7'd0);
    send_mode(6'd0, CM_ZERO_DEN);
    send_mode(6'd1, CM_TYPICAL);
    send_mode(6'd0, CM_FULL_BUSY);

    // small frame: idle over total, wrapping counters, all ones, huge deltas
    write_count(7'd4);
    send_mode(6'd0, CM_IDLE_OVER);
    send_mode(6'd1, CM_TYPICAL);
    send_raw(6'd2, '1, '1, '1);
    send_mode(6'd3, CM_BIG);
    send_mode(6'd7, CM_TYPICAL);
    send_mode(6'd2, CM_TYPICAL);
    send_mode(6'd2, CM_WIDE);
    send_mode(6'd3, CM_TYPICAL);

    // counts above the maximum act as the maximum
    write_count(7'd127);
    send_mode(6'd63, CM_TYPICAL);
    write_count(7'd65);
    send_mode(6'd62, CM_FULL_BUSY);
    send_mode(6'd63, CM_ZERO_DEN);

    // random phases, each with its own count setting
    counted_items = 0;
    while (counted_items < N_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 50)      write_count(CFG_W'($urandom_range(1, 8)));
      else if (r < 70) write_count(CFG_W'($urandom_range(9, 32)));
      else if (r < 80) write_count(CFG_W'($urandom_range(33, 64)));
      else if (r < 85) write_count(7'd0);
      else if (r < 90) write_count(7'd64);
      else if (r < 95) write_count(7'd127);
      else             write_count(CFG_W'($urandom_range(65, 127)));
      calm   = ($urandom_range(0, 99) < 20);
      frames = $urandom_range(1, 4);
      for (int f = 0; f < frames; f++) run_frame();
    end
    calm = 0;

    wait_idle();
    repeat (150) @(posedge clk);
    if (sb.pending_results.size() != 0) sb.report_mismatch("results left pending", 0,
                                                           sb.pending_results.size());
    if (sb.mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/lbpm_pkg.sv
rtl/lbpm_hist.sv
rtl/lbpm_serial.sv
rtl/lbpm_div.sv
rtl/lp_busy_percent_monitor.sv
test/testbench.sv
